FILE: rtl/core/tbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbt_pkg
// Shared widths, codes and types of the triangle tangent/bitangent core.
// ----------------------------------------------------------------------------
package tbt_pkg;

   // Field widths
   localparam int COORD_WIDTH = 16;
   localparam int OUT_WIDTH   = 32;

   // Internal datapath widths
   localparam int DELTA_W   = COORD_WIDTH + 1;        // b - a, c - a
   localparam int PROD_W    = 2 * DELTA_W;            // one cross product
   localparam int DIFF_W    = PROD_W + 1;             // difference of two products
   localparam int QUOT_SH   = 20;                     // 16 + 12 - 8
   localparam int DVD_W     = DIFF_W + QUOT_SH + 1;   // scaled numerator plus rounding
   localparam int REM_W     = DIFF_W + 1;
   localparam int DIV_STEPS = DVD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int N_VEC     = 6;

   // Product selector: determinant, tangent x/y/z, bitangent x/y/z
   localparam logic [2:0] SEL_DET = 3'd0;
   localparam logic [2:0] SEL_TX  = 3'd1;
   localparam logic [2:0] SEL_TY  = 3'd2;
   localparam logic [2:0] SEL_TZ  = 3'd3;
   localparam logic [2:0] SEL_BX  = 3'd4;
   localparam logic [2:0] SEL_BY  = 3'd5;
   localparam logic [2:0] SEL_BZ  = 3'd6;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_A,
      OP_LOAD_B,
      OP_LOAD_C,
      OP_MUL_A,
      OP_MUL_B,
      OP_SUB,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_STORE,
      OP_DEGEN
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] sel;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_SUB,
      ST_CHECK,
      ST_DIV_INIT,
      ST_DIV,
      ST_STORE,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/core/tbt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbt_req_if / tbt_rsp_if
// Valid/ready channels for vertex beats and tangent-space result beats.
// ----------------------------------------------------------------------------
interface tbt_req_if;
   import tbt_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          first_vertex;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic signed [COORD_WIDTH-1:0] tex_u;
   logic signed [COORD_WIDTH-1:0] tex_v;

   modport source (output valid, first_vertex, pos_x, pos_y, pos_z, tex_u, tex_v,
                   input ready);
   modport sink   (input valid, first_vertex, pos_x, pos_y, pos_z, tex_u, tex_v,
                   output ready);
endinterface

interface tbt_rsp_if;
   import tbt_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] tangent_x;
   logic signed [OUT_WIDTH-1:0] tangent_y;
   logic signed [OUT_WIDTH-1:0] tangent_z;
   logic signed [OUT_WIDTH-1:0] bitangent_x;
   logic signed [OUT_WIDTH-1:0] bitangent_y;
   logic signed [OUT_WIDTH-1:0] bitangent_z;
   logic                        degenerate;

   modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                   bitangent_y, bitangent_z, degenerate, input ready);
   modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                   bitangent_y, bitangent_z, degenerate, output ready);
endinterface

FILE: rtl/core/tbt_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbt_dpath
// Vertex store, shared 17x17 multiplier, subtractor, bit-serial divider and
// saturating result registers, driven one command per cycle.
// ----------------------------------------------------------------------------
module tbt_dpath import tbt_pkg::*; (
   input  logic                          clock,
   input  cmd_type                       cmd,
   output stat_type                      stat,
   input  logic signed [COORD_WIDTH-1:0] in_pos_x,
   input  logic signed [COORD_WIDTH-1:0] in_pos_y,
   input  logic signed [COORD_WIDTH-1:0] in_pos_z,
   input  logic signed [COORD_WIDTH-1:0] in_tex_u,
   input  logic signed [COORD_WIDTH-1:0] in_tex_v,
   output logic signed [OUT_WIDTH-1:0]   res_vec [0:N_VEC-1],
   output logic                          res_degen
);

   logic signed [COORD_WIDTH-1:0] a_pos_ff [0:2];
   logic signed [COORD_WIDTH-1:0] b_pos_ff [0:2];
   logic signed [COORD_WIDTH-1:0] a_u_ff, a_v_ff, b_u_ff, b_v_ff;
   logic signed [DELTA_W-1:0]     dp1_ff [0:2];
   logic signed [DELTA_W-1:0]     dp2_ff [0:2];
   logic signed [DELTA_W-1:0]     du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [PROD_W-1:0]      p1_ff, p2_ff;
   logic signed [DIFF_W-1:0]      num_ff, det_ff;
   logic        [DIFF_W-1:0]      dmag_ff;
   logic        [DVD_W-1:0]       dvd_ff, quo_ff;
   logic        [REM_W-1:0]       rem_ff;
   logic                          neg_ff;
   logic signed [OUT_WIDTH-1:0]   res_ff [0:N_VEC-1];
   logic                          degen_ff;

   logic signed [COORD_WIDTH-1:0] in_pos [0:2];
   logic signed [DELTA_W-1:0]     op_a, op_b;
   logic signed [PROD_W-1:0]      prod;
   logic        [1:0]             lane;
   logic signed [DIFF_W-1:0]      diff;
   logic        [DIFF_W-1:0]      num_mag, det_mag;
   logic        [REM_W-1:0]       rem_sh;
   logic                          q_bit;
   logic signed [OUT_WIDTH-1:0]   sat_val;
   logic        [2:0]             res_idx;

   localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(1) << (OUT_WIDTH - 1);
   localparam logic [DVD_W-1:0] POS_LIM = NEG_LIM - DVD_W'(1);

   assign in_pos[0] = in_pos_x;
   assign in_pos[1] = in_pos_y;
   assign in_pos[2] = in_pos_z;

   // Pick multiplier operands for the selected term and half
   always_comb begin
      lane = 2'd0;
      op_a = du1_ff;
      op_b = dv2_ff;
      case (cmd.sel)
         SEL_DET: begin
            op_a = (cmd.op == OP_MUL_B) ? dv1_ff : du1_ff;
            op_b = (cmd.op == OP_MUL_B) ? du2_ff : dv2_ff;
         end
         SEL_TX, SEL_TY, SEL_TZ: begin
            lane = 2'(cmd.sel - SEL_TX);
            op_a = (cmd.op == OP_MUL_B) ? dp2_ff[lane] : dp1_ff[lane];
            op_b = (cmd.op == OP_MUL_B) ? dv1_ff : dv2_ff;
         end
         SEL_BX, SEL_BY, SEL_BZ: begin
            lane = 2'(cmd.sel - SEL_BX);
            op_a = (cmd.op == OP_MUL_B) ? dp1_ff[lane] : dp2_ff[lane];
            op_b = (cmd.op == OP_MUL_B) ? du2_ff : du1_ff;
         end
         default: begin
            lane = 2'd0;
         end
      endcase
   end

   assign prod    = PROD_W'(op_a) * PROD_W'(op_b);
   assign diff    = DIFF_W'(p1_ff) - DIFF_W'(p2_ff);
   assign num_mag = num_ff[DIFF_W-1] ? DIFF_W'(-num_ff) : DIFF_W'(num_ff);
   assign det_mag = det_ff[DIFF_W-1] ? DIFF_W'(-det_ff) : DIFF_W'(det_ff);
   assign rem_sh  = {rem_ff[REM_W-2:0], dvd_ff[DVD_W-1]};
   assign q_bit   = (rem_sh >= REM_W'(dmag_ff));
   assign res_idx = cmd.sel - SEL_TX;

   // Clamp the rounded quotient to the output range and apply the sign
   always_comb begin
      if (neg_ff) begin
         sat_val = (quo_ff > NEG_LIM) ? OUT_WIDTH'(NEG_LIM) : OUT_WIDTH'(DVD_W'(0) - quo_ff);
      end else begin
         sat_val = (quo_ff > POS_LIM) ? OUT_WIDTH'(POS_LIM) : OUT_WIDTH'(quo_ff);
      end
   end

   // Advance the datapath by one command
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD_A: begin
            for (int i = 0; i < 3; i++) a_pos_ff[i] <= in_pos[i];
            a_u_ff <= in_tex_u;
            a_v_ff <= in_tex_v;
         end
         OP_LOAD_B: begin
            for (int i = 0; i < 3; i++) b_pos_ff[i] <= in_pos[i];
            b_u_ff <= in_tex_u;
            b_v_ff <= in_tex_v;
         end
         OP_LOAD_C: begin
            for (int i = 0; i < 3; i++) begin
               dp1_ff[i] <= DELTA_W'(b_pos_ff[i]) - DELTA_W'(a_pos_ff[i]);
               dp2_ff[i] <= DELTA_W'(in_pos[i]) - DELTA_W'(a_pos_ff[i]);
            end
            du1_ff <= DELTA_W'(b_u_ff) - DELTA_W'(a_u_ff);
            dv1_ff <= DELTA_W'(b_v_ff) - DELTA_W'(a_v_ff);
            du2_ff <= DELTA_W'(in_tex_u) - DELTA_W'(a_u_ff);
            dv2_ff <= DELTA_W'(in_tex_v) - DELTA_W'(a_v_ff);
         end
         OP_MUL_A: begin
            p1_ff <= prod;
         end
         OP_MUL_B: begin
            p2_ff <= prod;
         end
         OP_SUB: begin
            num_ff <= diff;
            if (cmd.sel == SEL_DET) begin
               det_ff   <= diff;
               degen_ff <= (diff == '0);
            end
         end
         OP_DIV_INIT: begin
            dvd_ff  <= (DVD_W'(num_mag) << QUOT_SH) + DVD_W'(det_mag >> 1);
            dmag_ff <= det_mag;
            neg_ff  <= num_ff[DIFF_W-1] ^ det_ff[DIFF_W-1];
            rem_ff  <= '0;
            quo_ff  <= '0;
         end
         OP_DIV_STEP: begin
            dvd_ff <= dvd_ff << 1;
            rem_ff <= q_bit ? rem_sh - REM_W'(dmag_ff) : rem_sh;
            quo_ff <= {quo_ff[DVD_W-2:0], q_bit};
         end
         OP_STORE: begin
            res_ff[res_idx] <= sat_val;
         end
         OP_DEGEN: begin
            for (int i = 0; i < N_VEC; i++) res_ff[i] <= '0;
         end
         default: begin
         end
      endcase
   end

   assign stat.det_zero = (det_ff == '0);
   assign res_vec       = res_ff;
   assign res_degen     = degen_ff;

endmodule

FILE: rtl/core/tbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbt_ctrl
// Sequencer: tracks vertex collection and steps the datapath through the
// determinant, six numerators, six divisions and the result handoff.
// ----------------------------------------------------------------------------
module tbt_ctrl import tbt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_first,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type         state_ff, state_in;
   logic [1:0]        count_ff, count_in;
   logic [2:0]        sel_ff, sel_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 2'd0;
         sel_ff   <= SEL_DET;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sel_ff   <= sel_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      sel_in    = sel_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.op    = OP_NONE;
      cmd.sel   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_first) begin
                  cmd.op   = OP_LOAD_A;
                  count_in = 2'd1;
               end else if (count_ff == 2'd1) begin
                  cmd.op   = OP_LOAD_B;
                  count_in = 2'd2;
               end else if (count_ff == 2'd2) begin
                  cmd.op   = OP_LOAD_C;
                  count_in = 2'd3;
                  sel_in   = SEL_DET;
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_MUL_A: begin
            cmd.op   = OP_MUL_A;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.op   = OP_MUL_B;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.op   = OP_SUB;
            state_in = (sel_ff == SEL_DET) ? ST_CHECK : ST_DIV_INIT;
         end
         ST_CHECK: begin
            if (stat.det_zero) begin
               cmd.op   = OP_DEGEN;
               state_in = ST_RESP;
            end else begin
               sel_in   = SEL_TX;
               state_in = ST_MUL_A;
            end
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.op = OP_STORE;
            if (sel_ff == SEL_BZ) begin
               state_in = ST_RESP;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_MUL_A;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/triangle_tangent_bitangent_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_core
// Tangent and bitangent of a textured triangle from three streamed vertices.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one vertex per beat: position Q8.8, texcoord Q4.12 and a
//   first_vertex flag that restarts collection. The first two vertices are
//   stored. Vertices with no triangle open (none flagged first yet, or a
//   triangle already finished) are dropped.
//   The third vertex starts the computation; rsp_chan then carries one beat
//   with tangent and bitangent in Q16.16 (rounded, saturated) and a
//   degenerate flag when the texture determinant is zero (vectors zero).
//   A degenerate triangle ends once the determinant is found. Each output
//   needs two multiplies on the one shared multiplier, a subtract and a
//   56-step restoring divider that retires one quotient bit per cycle, so
//   the divisions take most of the work.
//   req_chan is not ready while a triangle is in work or its result waits.
//   A stalled rsp_chan holds the result beat stable until taken.
//   Reset discards the collected vertices and returns to idle.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent_core import tbt_pkg::*; (
   input logic    clock,
   input logic    reset,
   tbt_req_if.sink   req_chan,
   tbt_rsp_if.source rsp_chan
);

   cmd_type                     cmd;
   stat_type                    stat;
   logic signed [OUT_WIDTH-1:0] res_vec [0:N_VEC-1];
   logic                        res_degen;

   tbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_first (req_chan.first_vertex),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   tbt_dpath u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .stat      (stat),
      .in_pos_x  (req_chan.pos_x),
      .in_pos_y  (req_chan.pos_y),
      .in_pos_z  (req_chan.pos_z),
      .in_tex_u  (req_chan.tex_u),
      .in_tex_v  (req_chan.tex_v),
      .res_vec   (res_vec),
      .res_degen (res_degen)
   );

   assign rsp_chan.tangent_x   = res_vec[0];
   assign rsp_chan.tangent_y   = res_vec[1];
   assign rsp_chan.tangent_z   = res_vec[2];
   assign rsp_chan.bitangent_x = res_vec[3];
   assign rsp_chan.bitangent_y = res_vec[4];
   assign rsp_chan.bitangent_z = res_vec[5];
   assign rsp_chan.degenerate  = res_degen;

   // Never take a vertex while a result beat is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_chan.valid && req_chan.ready))
      else $error("vertex accepted while result pending");

   // A degenerate result carries zero vectors
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.degenerate) |->
      (rsp_chan.tangent_x == '0 && rsp_chan.tangent_y == '0 &&
       rsp_chan.tangent_z == '0 && rsp_chan.bitangent_x == '0 &&
       rsp_chan.bitangent_y == '0 && rsp_chan.bitangent_z == '0))
      else $error("degenerate result with nonzero vectors");

   // Reset leaves the block idle and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_chan.ready && !rsp_chan.valid))
      else $error("block not idle after reset");

endmodule

FILE: dv/triangle_tangent_bitangent_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_core_tb
// Streams vertex beats with random idling on both channels and checks every
// result beat, field by field, against an in-bench tangent/bitangent predictor.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent_core_tb;
   import tbt_pkg::*;

   typedef struct packed {
      logic                          first;
      logic signed [COORD_WIDTH-1:0] px, py, pz, tu, tv;
   } vertex_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] tx, ty, tz, bx, by, bz;
      logic                        degen;
   } frame_type;

   typedef struct {
      vertex_type vtx;
      logic       has_exp;
      frame_type  exp_frame;
   } stim_row_type;

   localparam logic signed [OUT_WIDTH-1:0] SAT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [OUT_WIDTH-1:0] SAT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};
   localparam int RESULT_LATENCY = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   tbt_req_if req_chan ();
   tbt_rsp_if rsp_chan ();

   triangle_tangent_bitangent_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.first_vertex = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pos_z = '0;
      req_chan.tex_u = '0;
      req_chan.tex_v = '0;
      rsp_chan.ready = 1'b0;
   end

   // Predictor state: held vertices a and b and the collection count
   logic signed [63:0] held_pos [6];
   logic signed [63:0] held_tex [4];
   int unsigned        tri_count;
   frame_type          frame_queue [$];
   int                 error_count;
   bit                 quiet_tail;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // Q16.16 quotient of magnitudes, rounded half away, saturated
   function automatic logic signed [OUT_WIDTH-1:0] scaled_quotient(
         input logic signed [63:0] num, input logic signed [63:0] den);
      logic [63:0] n, d, q;
      logic        neg;
      n = num[63] ? -num : num;
      d = den[63] ? -den : den;
      neg = num[63] ^ den[63];
      q = ((n << 20) + (d >> 1)) / d;
      if (neg) begin
         if (q > {1'b1, {(OUT_WIDTH-1){1'b0}}}) return SAT_MIN;
         return -q[OUT_WIDTH-1:0];
      end
      if (q > SAT_MAX) return SAT_MAX;
      return q[OUT_WIDTH-1:0];
   endfunction

   // Advance the vertex collector; return 1 with a frame when a triangle closes
   function automatic bit tangent_frame(input vertex_type v, output frame_type f);
      logic signed [63:0] p [3];
      logic signed [63:0] dp1 [3];
      logic signed [63:0] dp2 [3];
      logic signed [63:0] u, w, du1, dv1, du2, dv2, det;
      logic signed [OUT_WIDTH-1:0] r [6];
      p[0] = 64'(v.px); p[1] = 64'(v.py); p[2] = 64'(v.pz);
      u = 64'(v.tu); w = 64'(v.tv);
      f = '0;
      if (v.first) begin
         for (int i = 0; i < 3; i++) held_pos[i] = p[i];
         held_tex[0] = u; held_tex[1] = w;
         tri_count = 1;
         return 0;
      end
      if (tri_count == 1) begin
         for (int i = 0; i < 3; i++) held_pos[3+i] = p[i];
         held_tex[2] = u; held_tex[3] = w;
         tri_count = 2;
         return 0;
      end
      if (tri_count != 2) return 0;
      tri_count = 3;
      for (int i = 0; i < 3; i++) begin
         dp1[i] = held_pos[3+i] - held_pos[i];
         dp2[i] = p[i] - held_pos[i];
      end
      du1 = held_tex[2] - held_tex[0];
      dv1 = held_tex[3] - held_tex[1];
      du2 = u - held_tex[0];
      dv2 = w - held_tex[1];
      det = du1 * dv2 - dv1 * du2;
      if (det == 0) begin
         f.degen = 1'b1;
         return 1;
      end
      for (int i = 0; i < 3; i++) begin
         r[i]   = scaled_quotient(dp1[i] * dv2 - dp2[i] * dv1, det);
         r[3+i] = scaled_quotient(dp2[i] * du1 - dp1[i] * du2, det);
      end
      f.tx = r[0]; f.ty = r[1]; f.tz = r[2];
      f.bx = r[3]; f.by = r[4]; f.bz = r[5];
      return 1;
   endfunction

   function automatic vertex_type mk(input logic first, input int px, input int py,
                                     input int pz, input int tu, input int tv);
      vertex_type v;
      v.first = first;
      v.px = 16'(px); v.py = 16'(py); v.pz = 16'(pz);
      v.tu = 16'(tu); v.tv = 16'(tv);
      return v;
   endfunction

   function automatic vertex_type rand_vertex(input logic first);
      vertex_type v;
      v = {first, 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom)};
      // Often keep coordinates small so quotients stay in range
      if ($urandom_range(0, 2) == 0) begin
         v.px = $signed(v.px) >>> 6; v.py = $signed(v.py) >>> 6;
         v.pz = $signed(v.pz) >>> 6;
      end
      return v;
   endfunction

   // Drive one vertex beat and predict its result; valid may drop for an idle gap first
   task automatic send_vertex(input vertex_type v, input logic has_exp,
                              input frame_type exp_f);
      frame_type f;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.first_vertex <= v.first;
      req_chan.pos_x <= v.px; req_chan.pos_y <= v.py; req_chan.pos_z <= v.pz;
      req_chan.tex_u <= v.tu; req_chan.tex_v <= v.tv;
      do @(posedge clock); while (!req_chan.ready);
      if (tangent_frame(v, f)) begin
         if (has_exp && f !== exp_f)
            report_mismatch("directed row degenerate", 64'(f.degen), 64'(exp_f.degen));
         frame_queue.push_back(f);
      end
   endtask

   // Result sink with random stalls, then field checks
   initial begin
      frame_type want;
      int        stall;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (frame_queue.size() == 0) begin
               report_mismatch("unexpected beat", 64'(rsp_chan.tangent_x), 64'd0);
            end else begin
               want = frame_queue.pop_front();
               if (rsp_chan.tangent_x !== want.tx)
                  report_mismatch("tangent_x", 64'(rsp_chan.tangent_x), 64'(want.tx));
               if (rsp_chan.tangent_y !== want.ty)
                  report_mismatch("tangent_y", 64'(rsp_chan.tangent_y), 64'(want.ty));
               if (rsp_chan.tangent_z !== want.tz)
                  report_mismatch("tangent_z", 64'(rsp_chan.tangent_z), 64'(want.tz));
               if (rsp_chan.bitangent_x !== want.bx)
                  report_mismatch("bitangent_x", 64'(rsp_chan.bitangent_x), 64'(want.bx));
               if (rsp_chan.bitangent_y !== want.by)
                  report_mismatch("bitangent_y", 64'(rsp_chan.bitangent_y), 64'(want.by));
               if (rsp_chan.bitangent_z !== want.bz)
                  report_mismatch("bitangent_z", 64'(rsp_chan.bitangent_z), 64'(want.bz));
               if (rsp_chan.degenerate !== want.degen)
                  report_mismatch("degenerate", 64'(rsp_chan.degenerate), 64'(want.degen));
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 12);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stimulus
   initial begin
      stim_row_type table_rows [$];
      stim_row_type row;
      frame_type    zero_f, degen_f;
      int           kind;
      error_count = 0;
      quiet_tail = 0;
      tri_count = 0;
      foreach (held_pos[i]) held_pos[i] = '0;
      foreach (held_tex[i]) held_tex[i] = '0;
      zero_f = '0;
      degen_f = '0;
      degen_f.degen = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: ignored vertices, degenerate, unit, extremes, restart
      row.has_exp = 1'b0; row.exp_frame = zero_f;
      row.vtx = mk(0, 100, 200, 300, 1, 2);       table_rows.push_back(row);
      row.vtx = mk(0, -5, 5, 7, 9, 11);           table_rows.push_back(row);
      row.vtx = mk(1, 0, 0, 0, 0, 0);             table_rows.push_back(row);
      row.vtx = mk(0, 256, 0, 0, 4096, 0);        table_rows.push_back(row);
      row.vtx = mk(0, 0, 256, 0, 8192, 0);
      row.has_exp = 1'b1; row.exp_frame = degen_f; table_rows.push_back(row);
      row.has_exp = 1'b0;
      row.vtx = mk(0, 1, 2, 3, 4, 5);             table_rows.push_back(row);
      row.vtx = mk(1, 0, 0, 0, 0, 0);             table_rows.push_back(row);
      row.vtx = mk(0, 256, 0, 0, 4096, 0);        table_rows.push_back(row);
      row.vtx = mk(0, 0, 256, 0, 0, 4096);        table_rows.push_back(row);
      row.vtx = mk(1, 32767, -32768, 32767, -32768, 32767); table_rows.push_back(row);
      row.vtx = mk(0, -32768, 32767, -32768, 32767, -32768); table_rows.push_back(row);
      row.vtx = mk(0, 32767, 32767, -32768, -32768, -32767); table_rows.push_back(row);
      row.vtx = mk(1, -32768, -32768, -32768, 0, 0); table_rows.push_back(row);
      row.vtx = mk(0, 32767, 32767, 32767, 1, 0); table_rows.push_back(row);
      row.vtx = mk(0, 32767, -32768, 0, 0, 1);    table_rows.push_back(row);
      row.vtx = mk(1, 0, 0, 0, 0, 0);             table_rows.push_back(row);
      row.vtx = mk(1, 3, 3, 3, 3, 3);             table_rows.push_back(row);
      row.vtx = mk(0, 9, 8, 7, -1, -1);           table_rows.push_back(row);
      row.vtx = mk(0, -9, 8, -7, 1, -2);          table_rows.push_back(row);
      row.vtx = mk(0, -1, -1, -1, -1, -1);        table_rows.push_back(row);
      foreach (table_rows[i])
         send_vertex(table_rows[i].vtx, table_rows[i].has_exp, table_rows[i].exp_frame);
      req_chan.valid <= 1'b0;

      // Hold off until the block drains
      wait (frame_queue.size() == 0);

      // Random: mostly well-formed triangles, some noise and broken ones
      for (int n = 0; n < 1500; ) begin
         if (n > 1300) quiet_tail = 1;
         kind = $urandom_range(0, 9);
         send_vertex(rand_vertex(1), 0, zero_f);
         send_vertex(rand_vertex(0), 0, zero_f);
         n += 2;
         if (kind == 0) continue;
         if (kind == 1) begin
            send_vertex(rand_vertex(0), 0, zero_f);
            n++;
         end
         send_vertex(rand_vertex(0), 0, zero_f);
         n++;
         if (kind == 2) begin
            send_vertex(rand_vertex(0), 0, zero_f);
            n++;
         end
      end
      req_chan.valid <= 1'b0;

      wait (frame_queue.size() == 0);
      repeat (RESULT_LATENCY) @(posedge clock);
      if (error_count == 0 && frame_queue.size() == 0)
         $display("PASS triangle_tangent_bitangent_core");
      else
         $display("FAIL triangle_tangent_bitangent_core");
      $finish;
   end

   // Timeout guard
   initial begin
      #30_000_000;
      $display("FAIL triangle_tangent_bitangent_core");
      $finish;
   end

endmodule
